// ----- src/kcl_pkg.sv -----
package kcl_pkg;

  localparam int DIGIT_W   = 4;
  localparam int SECRET_W  = 32;
  localparam int SLEN_W    = 4;
  localparam int MAX_SECRET = 8;
  localparam int TICK_W    = 16;
  localparam int FAIL_W    = 3;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CMD_W-1:0] CMD_DIGIT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SECRET_CODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNLOCK_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES  = 3'd4;

  localparam logic [SECRET_W-1:0] RST_SECRET_CODE   = 32'h0000_1234;
  localparam logic [SLEN_W-1:0]   RST_SECRET_LENGTH = 4'd4;
  localparam logic [TICK_W-1:0]   RST_UNLOCK_TICKS  = 16'd3000;
  localparam logic [TICK_W-1:0]   RST_LOCKOUT_TICKS = 16'd6000;
  localparam logic [FAIL_W-1:0]   RST_MAX_FAILURES  = 3'd3;

  typedef struct packed {
    logic [FAIL_W-1:0] failure_count;
    logic              code_wrong;
    logic [3:0]        entry_length;
    logic              keypad_locked_out;
    logic              door_unlocked;
  } kcl_result_t;

endpackage

// ----- src/kcl_match.sv -----
module kcl_match #(
  parameter int NCMP = 8,
  parameter int CW   = 4
) (
  input  logic [NCMP*kcl_pkg::DIGIT_W-1:0] entry_digits,
  input  logic [CW-1:0]                    entry_count,
  input  logic                             entry_overflow,
  input  logic [kcl_pkg::SECRET_W-1:0]     secret_code,
  input  logic [kcl_pkg::SLEN_W-1:0]       secret_length,
  output logic                             match
);
  import kcl_pkg::*;

  localparam int XW = (CW > SLEN_W) ? CW : SLEN_W;

  logic [SLEN_W-1:0] len;
  logic [NCMP-1:0]   diff;

  // length clamped to 1..8
  always_comb begin
    if (secret_length == '0) begin
      len = SLEN_W'(1);
    end else if (secret_length > SLEN_W'(MAX_SECRET)) begin
      len = SLEN_W'(MAX_SECRET);
    end else begin
      len = secret_length;
    end
  end

  for (genvar i = 0; i < NCMP; i++) begin : g_cmp
    logic [2:0]         sel;
    logic [DIGIT_W-1:0] want;
    assign sel  = 3'(len - SLEN_W'(1) - SLEN_W'(i));
    assign want = secret_code[{sel, 2'b00} +: DIGIT_W];
    assign diff[i] = (SLEN_W'(i) < len) &&
                     (entry_digits[i*DIGIT_W +: DIGIT_W] != want);
  end

  assign match = !entry_overflow && (XW'(entry_count) == XW'(len)) && (diff == '0);

endmodule

// ----- src/keypad_code_lock_top.sv -----
// Keypad code lock. Each input word is one event (digit, clear, OK, timer tick or
// inside push button) and yields exactly one result word with the door, lockout,
// entry length, wrong-code flag and failure count as they stand after that event.
// Input words are registered and processed once the result register is free or being
// read, so a stalled output also holds the input register; one word per cycle is
// sustained while out_tready stays high.
// Configuration writes are taken any time (cfg_ready is tied high) and are meant to
// happen while no word is in flight.
module keypad_code_lock_top #(
  parameter int MAX_DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] cmd, [6:3] key_digit, [7] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] door_unlocked, [1] keypad_locked_out,
                                  // [5:2] entry_length, [6] code_wrong,
                                  // [9:7] failure_count, [15:10] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcl_pkg::SECRET_W-1:0]  cfg_data
);
  import kcl_pkg::*;

  localparam int CW   = $clog2(MAX_DIGITS + 1);
  localparam int IW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int NCMP = (MAX_DIGITS < MAX_SECRET) ? MAX_DIGITS : MAX_SECRET;
  localparam int XW   = (CW > 4) ? CW : 4;

  // configuration
  logic [SECRET_W-1:0] secret_code_r;
  logic [SLEN_W-1:0]   secret_length_r;
  logic [TICK_W-1:0]   unlock_ticks_r;
  logic [TICK_W-1:0]   lockout_ticks_r;
  logic [FAIL_W-1:0]   max_failures_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      secret_code_r   <= RST_SECRET_CODE;
      secret_length_r <= RST_SECRET_LENGTH;
      unlock_ticks_r  <= RST_UNLOCK_TICKS;
      lockout_ticks_r <= RST_LOCKOUT_TICKS;
      max_failures_r  <= RST_MAX_FAILURES;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SECRET_CODE:   secret_code_r   <= cfg_data;
        REG_SECRET_LENGTH: secret_length_r <= cfg_data[SLEN_W-1:0];
        REG_UNLOCK_TICKS:  unlock_ticks_r  <= cfg_data[TICK_W-1:0];
        REG_LOCKOUT_TICKS: lockout_ticks_r <= cfg_data[TICK_W-1:0];
        REG_MAX_FAILURES:  max_failures_r  <= cfg_data[FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               in_v_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [DIGIT_W-1:0] digit_r;
  logic               adv;

  // result register
  logic        out_v_r;
  kcl_result_t res_r;
  kcl_result_t res_nxt;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= in_tdata[2:0];
      digit_r <= in_tdata[6:3];
    end
  end

  // lock state
  logic [DIGIT_W-1:0] digits_r [MAX_DIGITS];
  logic [CW-1:0]      count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [FAIL_W-1:0]  failures_r, failures_nxt;
  logic               door_r, door_nxt;
  logic [TICK_W-1:0]  relock_r, relock_nxt;
  logic [TICK_W-1:0]  lockout_r, lockout_nxt;
  logic               wrong;

  logic [NCMP*DIGIT_W-1:0] digits_flat;
  logic                    match;
  logic                    keys_on;
  logic                    full;
  logic [FAIL_W-1:0]       fail_inc;
  logic [FAIL_W-1:0]       limit;
  logic [XW-1:0]           count_x;

  for (genvar i = 0; i < NCMP; i++) begin : g_flat
    assign digits_flat[i*DIGIT_W +: DIGIT_W] = digits_r[i];
  end

  kcl_match #(
    .NCMP (NCMP),
    .CW   (CW)
  ) u_match (
    .entry_digits   (digits_flat),
    .entry_count    (count_r),
    .entry_overflow (ovf_r),
    .secret_code    (secret_code_r),
    .secret_length  (secret_length_r),
    .match          (match)
  );

  assign keys_on  = (lockout_r == '0);
  assign full     = (count_r >= CW'(MAX_DIGITS));
  assign fail_inc = failures_r + FAIL_W'(1);
  assign limit    = (max_failures_r == '0) ? FAIL_W'(1) : max_failures_r;

  always_comb begin
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    failures_nxt = failures_r;
    door_nxt     = door_r;
    relock_nxt   = relock_r;
    lockout_nxt  = lockout_r;
    wrong        = 1'b0;
    priority if (cmd_r == CMD_DIGIT && keys_on) begin
      if (!full) begin
        count_nxt = count_r + CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end else if (cmd_r == CMD_CLEAR && keys_on) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (cmd_r == CMD_OK && keys_on) begin
      if (match) begin
        door_nxt   = 1'b1;
        relock_nxt = (unlock_ticks_r == '0) ? TICK_W'(1) : unlock_ticks_r;
      end else begin
        wrong        = 1'b1;
        count_nxt    = '0;
        ovf_nxt      = 1'b0;
        failures_nxt = fail_inc;
        // counter wrap also counts as reaching the limit
        if (fail_inc >= limit || fail_inc == '0) begin
          lockout_nxt  = (lockout_ticks_r == '0) ? TICK_W'(1) : lockout_ticks_r;
          door_nxt     = 1'b0;
          relock_nxt   = '0;
          failures_nxt = '0;
        end
      end
    end else if (cmd_r == CMD_TICK) begin
      if (relock_r != '0) begin
        relock_nxt = relock_r - TICK_W'(1);
        if (relock_r == TICK_W'(1)) begin
          door_nxt = 1'b0;
        end
      end
      if (lockout_r != '0) begin
        lockout_nxt = lockout_r - TICK_W'(1);
      end
    end else if (cmd_r == CMD_PUSH) begin
      door_nxt = 1'b1;
    end else begin
      // unknown command or key during lockout: no change
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_r      <= 1'b0;
      failures_r <= '0;
      door_r     <= 1'b0;
      relock_r   <= '0;
      lockout_r  <= '0;
    end else if (adv) begin
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      failures_r <= failures_nxt;
      door_r     <= door_nxt;
      relock_r   <= relock_nxt;
      lockout_r  <= lockout_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cmd_r == CMD_DIGIT && keys_on && !full) begin
      digits_r[count_r[IW-1:0]] <= digit_r;
    end
  end

  // result word
  assign count_x = XW'(count_nxt);

  always_comb begin
    res_nxt.door_unlocked     = door_nxt;
    res_nxt.keypad_locked_out = (lockout_nxt != '0);
    res_nxt.entry_length      = (count_x > XW'(15)) ? 4'd15 : count_x[3:0];
    res_nxt.code_wrong        = wrong;
    res_nxt.failure_count     = failures_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, res_r};

`ifndef SYNTHESIS
  a_fail_clear_in_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    (lockout_r != '0) |-> (failures_r == '0))
    else $error("failure count nonzero during lockout");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_DIGITS))
    else $error("entry count above buffer depth");

  a_relock_door: assert property (@(posedge clk) disable iff (!rst_n)
    (relock_r != '0) |-> door_r)
    else $error("relock timer running with door locked");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("processed word produced no result");
`endif

endmodule
